### sv/pas_pkg.sv
// Shared constants and types for the polar angle sort block.
package pas_pkg;

  localparam int MAX_POINTS   = 16;
  localparam int COORD_BITS   = 12;
  localparam int IDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int VEC_W        = COORD_BITS + 1;
  localparam int PROD_W       = 2 * VEC_W;
  localparam int CR_W         = PROD_W + 1;
  localparam int LOAD_INDEX_W = 4;
  localparam int OUT_COORD_W  = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } cfg_reg_t;

  // Angle key: a direction vector and the half plane relative to the anchor
  typedef struct packed {
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic                    half;
  } key_t;

  typedef struct packed {
    key_t                    key;
    logic [IDX_W-1:0]        idx;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
  } point_t;

  typedef struct packed {
    logic   valid;
    point_t pt;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctrl_t;

endpackage

### sv/pas_key.sv
// Angle key stage: turns one stored point into its registered angle key.
module pas_key (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [pas_pkg::COORD_BITS-1:0] x,
  input  logic [pas_pkg::COORD_BITS-1:0] y,
  input  logic [pas_pkg::IDX_W-1:0]      idx,
  input  logic [pas_pkg::COORD_BITS-1:0] anchor_x,
  input  logic [pas_pkg::COORD_BITS-1:0] anchor_y,
  input  logic [pas_pkg::COORD_BITS-1:0] center_x,
  input  logic [pas_pkg::COORD_BITS-1:0] center_y,
  output pas_pkg::entry_t                ent
);

  logic signed [pas_pkg::VEC_W-1:0]  ax, ay, bx, by;
  logic signed [pas_pkg::PROD_W-1:0] p_ab_y, p_ay_bx, p_ax_bx, p_ay_by;
  logic signed [pas_pkg::CR_W-1:0]   cr, dt;
  logic                              za, zb;
  pas_pkg::key_t                     key;
  logic                              vld;
  pas_pkg::point_t                   pt;

  assign ax = $signed({1'b0, anchor_x}) - $signed({1'b0, center_x});
  assign ay = $signed({1'b0, anchor_y}) - $signed({1'b0, center_y});
  assign bx = $signed({1'b0, x}) - $signed({1'b0, center_x});
  assign by = $signed({1'b0, y}) - $signed({1'b0, center_y});

  assign p_ab_y  = ax * by;
  assign p_ay_bx = ay * bx;
  assign p_ax_bx = ax * bx;
  assign p_ay_by = ay * by;

  assign cr = pas_pkg::CR_W'(p_ab_y) - pas_pkg::CR_W'(p_ay_bx);
  assign dt = pas_pkg::CR_W'(p_ax_bx) + pas_pkg::CR_W'(p_ay_by);

  assign za = (ax == '0) && (ay == '0);
  assign zb = (bx == '0) && (by == '0);

  always_comb begin
    priority if (za) begin
      // degenerate anchor: every point sits at angle 0
      key.vx   = '0;
      key.vy   = '0;
      key.half = 1'b0;
    end else if (zb) begin
      // point on the center: stand in the anchor direction
      key.vx   = ax;
      key.vy   = ay;
      key.half = 1'b0;
    end else begin
      key.vx   = bx;
      key.vy   = by;
      key.half = !((cr > 0) || ((cr == 0) && (dt > 0)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pt.key <= key;
    pt.idx <= idx;
    pt.x   <= x;
    pt.y   <= y;
  end

  assign ent.valid = vld;
  assign ent.pt    = pt;

endmodule

### sv/pas_cell.sv
// Insertion cell: holds one sorted entry, takes the new key or a neighbor's entry.
module pas_cell (
  input  logic                clk,
  input  logic                rst,
  input  pas_pkg::cell_ctrl_t ctrl,
  input  pas_pkg::entry_t     new_ent,
  input  pas_pkg::entry_t     left_ent,
  input  logic                left_lt,
  input  pas_pkg::entry_t     right_ent,
  output pas_pkg::entry_t     ent,
  output logic                lt
);

  logic                              vld, vld_next;
  pas_pkg::point_t                   pt, pt_next;
  logic signed [pas_pkg::PROD_W-1:0] p0, p1;
  logic signed [pas_pkg::CR_W-1:0]   cr;
  logic                              less;

  assign p0 = new_ent.pt.key.vx * pt.key.vy;
  assign p1 = new_ent.pt.key.vy * pt.key.vx;
  assign cr = pas_pkg::CR_W'(p0) - pas_pkg::CR_W'(p1);

  always_comb begin
    if (new_ent.pt.key.half != pt.key.half) begin
      less = !new_ent.pt.key.half;
    end else begin
      less = cr > 0;
    end
  end

  // an empty cell always lets the new key in ahead of it
  assign lt = !vld || less;

  always_comb begin
    priority if (ctrl.shl) begin
      vld_next = right_ent.valid;
      pt_next  = right_ent.pt;
    end else if (ctrl.ins && lt && left_lt) begin
      vld_next = left_ent.valid;
      pt_next  = left_ent.pt;
    end else if (ctrl.ins && lt) begin
      vld_next = new_ent.valid;
      pt_next  = new_ent.pt;
    end else begin
      vld_next = vld;
      pt_next  = pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    pt <= pt_next;
  end

  assign ent.valid = vld;
  assign ent.pt    = pt;

endmodule

### sv/polar_angle_sort_top.sv
// Top level of the polar angle sort block: point store, key stage and insertion chain.
//
// Loads a set of points one beat per cycle while in_stall is low; the first point
// is the anchor. When the beat marked last_point arrives, the stored points are read
// back one per cycle, each turned into an exact angle key (cross and dot signs
// against the anchor vector, both vectors taken about center_x/center_y as they stand
// at that time) and broadcast into a chain of MAX_POINTS insertion cells, each of
// which compares the new key with its own using one cross product and either holds,
// takes the new entry or takes its left neighbor's. Ties keep load order. Once the
// chain has settled, the sorted points leave one beat per cycle from the head cell
// while the chain shifts left, as long as out_stall is low. The run time of a set is
// set by the single read port of the point store and the single output of the chain
// head. No input beat is taken between the last_point beat and the final result of
// its run. Points beyond MAX_POINTS are dropped and every result of that set carries
// dropped = 1; load_index wraps modulo 16.
module polar_angle_sort_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] point_x,
  input  logic [11:0] point_y,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  load_index,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic        last_result,
  output logic        dropped
);

  localparam int CW   = pas_pkg::COORD_BITS;
  localparam int NP   = pas_pkg::MAX_POINTS;
  localparam int IW   = pas_pkg::IDX_W;
  localparam int NW   = pas_pkg::CNT_W;
  localparam int LIW  = pas_pkg::LOAD_INDEX_W;
  localparam int OCW  = pas_pkg::OUT_COORD_W;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                 state;
  logic [NW-1:0]          count;
  logic [NW-1:0]          n_pts;
  logic [NW-1:0]          ptr;
  logic                   overflow;
  logic [CW-1:0]          center_x, center_y;
  logic [CW-1:0]          anchor_x, anchor_y;
  logic [2*CW-1:0]        store_mem [NP];
  logic                   rd_valid;
  logic [CW-1:0]          rd_x, rd_y;
  logic [IW-1:0]          rd_idx;
  logic                   in_accept, out_accept, room, issue;
  logic [CW-1:0]          px, py;
  pas_pkg::entry_t        key_ent;
  pas_pkg::entry_t        empty_ent;
  pas_pkg::cell_ctrl_t    ctrl;
  pas_pkg::entry_t        chain [NP];
  logic                   lt [NP];

  assign px = CW'(point_x);
  assign py = CW'(point_y);

  assign in_stall   = (state != ST_LOAD);
  assign in_accept  = in_valid && (state == ST_LOAD);
  assign room       = (count < NW'(NP));
  assign issue      = (state == ST_SORT) && (ptr != n_pts);
  assign out_valid  = (state == ST_EMIT) && chain[0].valid;
  assign out_accept = out_valid && !out_stall;
  assign empty_ent  = '0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pas_pkg::REG_CENTER_X: center_x <= CW'(cfg_data);
        pas_pkg::REG_CENTER_Y: center_y <= CW'(cfg_data);
      endcase
    end
  end

  // Sequencer: load the set, feed the chain, drain the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      n_pts    <= '0;
      ptr      <= '0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (room) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (last_point) begin
              // the last beat is stored too when there is room
              n_pts <= room ? count + 1'b1 : count;
              ptr   <= '0;
              state <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end else if (!rd_valid && !key_ent.valid) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_accept && last_result) begin
            count    <= '0;
            overflow <= 1'b0;
            state    <= ST_LOAD;
          end
        end
      endcase
    end
  end

  // Hold the anchor as raw coordinates; its vector is formed at sort time
  always_ff @(posedge clk) begin
    if (in_accept && room && (count == '0)) begin
      anchor_x <= px;
      anchor_y <= py;
    end
  end

  // Point store
  always_ff @(posedge clk) begin
    if (in_accept && room) begin
      store_mem[count[IW-1:0]] <= {px, py};
    end
  end

  always_ff @(posedge clk) begin
    {rd_x, rd_y} <= store_mem[ptr[IW-1:0]];
    rd_idx       <= ptr[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  pas_key u_key (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .x        (rd_x),
    .y        (rd_y),
    .idx      (rd_idx),
    .anchor_x (anchor_x),
    .anchor_y (anchor_y),
    .center_x (center_x),
    .center_y (center_y),
    .ent      (key_ent)
  );

  // Insert on a keyed beat, shift toward the head on each emitted beat
  assign ctrl.ins = key_ent.valid;
  assign ctrl.shl = out_accept;

  for (genvar i = 0; i < NP; i++) begin : g_cell
    pas_pkg::entry_t left_ent, right_ent;
    logic            left_lt;

    if (i == 0) begin : g_head
      assign left_ent = empty_ent;
      assign left_lt  = 1'b0;
    end else begin : g_mid
      assign left_ent = chain[i-1];
      assign left_lt  = lt[i-1];
    end

    if (i == NP - 1) begin : g_tail
      assign right_ent = empty_ent;
    end else begin : g_body
      assign right_ent = chain[i+1];
    end

    pas_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_ent   (key_ent),
      .left_ent  (left_ent),
      .left_lt   (left_lt),
      .right_ent (right_ent),
      .ent       (chain[i]),
      .lt        (lt[i])
    );
  end

  // Result beat comes straight from the head cell; it holds while stalled
  assign load_index  = LIW'(chain[0].pt.idx);
  assign out_x       = OCW'(chain[0].pt.x);
  assign out_y       = OCW'(chain[0].pt.y);
  assign last_result = !chain[1].valid;
  assign dropped     = overflow;

endmodule
